// File: design/bbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared widths, constants and types of the box regression delta decoder.
// ----------------------------------------------------------------------------
package bbd_pkg;

    localparam int COORD_FRAC_BITS = 4;
    localparam int DELTA_FRAC_BITS = 12;

    localparam int COORD_W     = 18;
    localparam int DELTA_W     = 16;
    localparam int SIZE_W      = 14;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = SIZE_W;

    localparam int IN_DATA_W  = 4 * COORD_W + 4 * DELTA_W;
    localparam int OUT_DATA_W = 4 * COORD_W;

    localparam int STAGES = 9;

    // box length and centre accumulation
    localparam int LEN_W        = COORD_W + 2;
    localparam int SCALE_SHIFT  = 17;
    localparam int HALF_SHIFT   = SCALE_SHIFT - 1;
    localparam int DELTA_SHIFT  = SCALE_SHIFT - DELTA_FRAC_BITS;
    localparam int DCL_W        = DELTA_W + LEN_W;
    localparam int ACC_W        = 64;
    localparam int R_W          = ACC_W - SCALE_SHIFT;
    localparam int OUT_MAX      = (1 << (COORD_W - 1)) - 1;
    localparam int OUT_MIN      = -(1 << (COORD_W - 1));

    // exp via 2^(d*log2e)
    localparam int LOG2E_Q16  = 94548;
    localparam int LOG2E_W    = 18;
    localparam int T_W        = DELTA_W + LOG2E_W;
    localparam int EXP_FRAC   = DELTA_FRAC_BITS + 16;
    localparam int N_W        = T_W - EXP_FRAC;
    localparam int F_W        = 16;
    localparam int HORNER_C3  = 5121;
    localparam int HORNER_C2  = 14823;
    localparam int HORNER_C1  = 45584;
    localparam int HORNER_C0  = 65536;
    localparam int C3_W       = 13;
    localparam int P1_W       = 15;
    localparam int P2_W       = 16;
    localparam int P3_W       = 17;
    localparam int EXP_CAP_N  = 23;
    localparam int EXP_CAP_SH = 40;
    localparam int EXP_ZERO_N = 32;
    localparam int SH_W       = 6;
    localparam int PROD_W     = P3_W + 1 + LEN_W;

    // clipping bound
    localparam int BOUND_W = SIZE_W + 1 + COORD_FRAC_BITS;
    localparam int CLIP_W  = (BOUND_W > COORD_W) ? BOUND_W : COORD_W;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_ENABLE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic              CLIP_ENABLE_RST  = 1'b1;
    localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RST  = 14'd1000;
    localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RST = 14'd600;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic [SIZE_W-1:0]         size_t;

    typedef struct packed {
        logic [STAGES-1:0] en;
    } pipe_ctrl_t;

endpackage

// File: design/bbox_delta_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbox_delta_decoder
// Decodes a proposal box and its regression deltas into predicted corners.
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid / s_tready  s_tdata: box and delta fields
// m_*       out  m_tvalid / m_tready  m_tdata: corners, m_tuser: saturated
// cfg_*     in   cfg_wr_en            cfg_index, cfg_data
//
// one item per cycle while the output is not stalled (nine register
// stages per axis from accept to result, both axes side by side)
// a stalled output holds the pipeline; empty stages still fill under a stall
// reset clears the stage valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module bbox_delta_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // box_x1, box_y1, box_x2, box_y2, delta_x, delta_y, delta_w, delta_h
    input  logic [bbd_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pred_x1, pred_y1, pred_x2, pred_y2
    output logic [bbd_pkg::OUT_DATA_W-1:0]      m_tdata,
    // saturated
    output logic                                m_tuser,
    input  logic                                cfg_wr_en,
    input  logic [bbd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bbd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bbd_pkg::*;

    logic       clip_enable_reg;
    size_t      image_width_reg;
    size_t      image_height_reg;
    pipe_ctrl_t ctrl;

    coord_t box_x1, box_y1, box_x2, box_y2;
    delta_t delta_x, delta_y, delta_w, delta_h;
    coord_t pred_x1, pred_y1, pred_x2, pred_y2;
    logic   sat_x, sat_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_enable_reg  <= CLIP_ENABLE_RST;
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CLIP_ENABLE:  clip_enable_reg  <= cfg_data[0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    assign box_x1  = s_tdata[0*COORD_W +: COORD_W];
    assign box_y1  = s_tdata[1*COORD_W +: COORD_W];
    assign box_x2  = s_tdata[2*COORD_W +: COORD_W];
    assign box_y2  = s_tdata[3*COORD_W +: COORD_W];
    assign delta_x = s_tdata[4*COORD_W + 0*DELTA_W +: DELTA_W];
    assign delta_y = s_tdata[4*COORD_W + 1*DELTA_W +: DELTA_W];
    assign delta_w = s_tdata[4*COORD_W + 2*DELTA_W +: DELTA_W];
    assign delta_h = s_tdata[4*COORD_W + 3*DELTA_W +: DELTA_W];

    bbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    bbd_axis u_axis_x (
        .clk         (clk),
        .ctrl        (ctrl),
        .a1          (box_x1),
        .a2          (box_x2),
        .d_ctr       (delta_x),
        .d_size      (delta_w),
        .clip_enable (clip_enable_reg),
        .size        (image_width_reg),
        .lo          (pred_x1),
        .hi          (pred_x2),
        .sat         (sat_x)
    );

    bbd_axis u_axis_y (
        .clk         (clk),
        .ctrl        (ctrl),
        .a1          (box_y1),
        .a2          (box_y2),
        .d_ctr       (delta_y),
        .d_size      (delta_h),
        .clip_enable (clip_enable_reg),
        .size        (image_height_reg),
        .lo          (pred_y1),
        .hi          (pred_y2),
        .sat         (sat_y)
    );

    assign m_tdata = {pred_y2, pred_x2, pred_y1, pred_x1};
    assign m_tuser = sat_x | sat_y;

endmodule

// File: design/bbd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_ctrl
// Valid bits and per-stage load enables of the decode pipeline.
// ----------------------------------------------------------------------------
module bbd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output bbd_pkg::pipe_ctrl_t ctrl
);
    import bbd_pkg::*;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] stage_en;

    // a stage loads when empty or when the next one loads
    always_comb
    begin
        stage_en[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
        begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (stage_en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[STAGES-1];
    assign ctrl.en  = stage_en;

endmodule

// File: design/bbd_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_axis
// One axis of the decode: length, centre shift, exp scale, round, saturate
// and clip, over nine register stages.
// ----------------------------------------------------------------------------
module bbd_axis (
    input  logic                clk,
    input  bbd_pkg::pipe_ctrl_t ctrl,
    input  bbd_pkg::coord_t     a1,
    input  bbd_pkg::coord_t     a2,
    input  bbd_pkg::delta_t     d_ctr,
    input  bbd_pkg::delta_t     d_size,
    input  logic                clip_enable,
    input  bbd_pkg::size_t      size,
    output bbd_pkg::coord_t     lo,
    output bbd_pkg::coord_t     hi,
    output logic                sat
);
    import bbd_pkg::*;

    typedef struct packed {
        logic   flag;
        coord_t value;
    } sat_t;

    function automatic sat_t saturate(input logic signed [R_W-1:0] r);
        sat_t s;
        s.flag  = 1'b0;
        s.value = COORD_W'(r);
        if (r > OUT_MAX)
        begin
            s.flag  = 1'b1;
            s.value = COORD_W'(OUT_MAX);
        end
        else if (r < OUT_MIN)
        begin
            s.flag  = 1'b1;
            s.value = COORD_W'(OUT_MIN);
        end
        return s;
    endfunction

    function automatic coord_t clip(input coord_t v, input logic en,
                                    input logic signed [BOUND_W-1:0] bound);
        logic signed [CLIP_W-1:0] c;
        c = CLIP_W'(v);
        if (en)
        begin
            if (c > CLIP_W'(bound))
            begin
                c = CLIP_W'(bound);
            end
            if (c < 0)
            begin
                c = '0;
            end
        end
        return COORD_W'(c);
    endfunction

    // stage 1
    logic signed [T_W-1:0]   s1_t_reg,   s1_t_next;
    logic signed [LEN_W-1:0] s1_len_reg, s1_len_next;
    coord_t                  s1_a1_reg;
    delta_t                  s1_dc_reg;
    // stage 2
    logic [P1_W-1:0]         s2_p1_reg,  s2_p1_next;
    logic [F_W-1:0]          s2_f_reg;
    logic signed [N_W-1:0]   s2_n_reg;
    logic signed [LEN_W-1:0] s2_len_reg;
    logic signed [ACC_W-1:0] s2_ctr_reg, s2_ctr_next;
    logic signed [DCL_W-1:0] s2_dcl_reg, s2_dcl_next;
    logic [F_W-1:0]          f1;
    logic [F_W+C3_W-1:0]     q1;
    // stage 3
    logic [P2_W-1:0]         s3_p2_reg,  s3_p2_next;
    logic [F_W-1:0]          s3_f_reg;
    logic signed [N_W-1:0]   s3_n_reg;
    logic signed [LEN_W-1:0] s3_len_reg;
    logic signed [ACC_W-1:0] s3_pc_reg,  s3_pc_next;
    logic [P1_W+F_W-1:0]     q2;
    // stage 4
    logic [P3_W-1:0]         s4_p3_reg,  s4_p3_next;
    logic signed [N_W-1:0]   s4_n_reg;
    logic signed [LEN_W-1:0] s4_len_reg;
    logic signed [ACC_W-1:0] s4_pc_reg;
    logic [P2_W+F_W-1:0]     q3;
    // stage 5
    logic [P3_W-1:0]         s5_m_reg,   s5_m_next;
    logic [SH_W-1:0]         s5_sh_reg,  s5_sh_next;
    logic signed [LEN_W-1:0] s5_len_reg;
    logic signed [ACC_W-1:0] s5_pc_reg;
    logic [N_W-1:0]          shr;
    // stage 6
    logic signed [PROD_W-1:0] s6_prod_reg, s6_prod_next;
    logic [SH_W-1:0]          s6_sh_reg;
    logic signed [ACC_W-1:0]  s6_pc_reg;
    // stage 7
    logic signed [ACC_W-1:0] s7_half_reg, s7_half_next;
    logic signed [ACC_W-1:0] s7_pc_reg;
    // stage 8
    sat_t                    s8_lo_reg,  s8_lo_next;
    sat_t                    s8_hi_reg,  s8_hi_next;
    logic signed [ACC_W-1:0] lo_sum, hi_sum;
    // stage 9
    coord_t                  s9_lo_reg,  s9_lo_next;
    coord_t                  s9_hi_reg,  s9_hi_next;
    logic                    s9_sat_reg;
    logic signed [BOUND_W-1:0] bound;

    always_comb
    begin
        s1_len_next = LEN_W'(a2) - LEN_W'(a1) + LEN_W'(1 << COORD_FRAC_BITS);
        s1_t_next   = T_W'(d_size) * T_W'(LOG2E_Q16);
    end

    // first horner step, centre and centre shift product
    always_comb
    begin
        f1          = s1_t_reg[EXP_FRAC-1 -: F_W];
        q1          = (F_W + C3_W)'(HORNER_C3) * (F_W + C3_W)'(f1);
        s2_p1_next  = P1_W'(HORNER_C2) + P1_W'(q1[F_W+C3_W-1:F_W]);
        s2_ctr_next = (ACC_W'(s1_a1_reg) <<< SCALE_SHIFT)
                    + (ACC_W'(s1_len_reg) <<< HALF_SHIFT)
                    + ACC_W'(1 << HALF_SHIFT);
        s2_dcl_next = DCL_W'(s1_dc_reg) * DCL_W'(s1_len_reg);
    end

    always_comb
    begin
        q2         = (P1_W + F_W)'(s2_p1_reg) * (P1_W + F_W)'(s2_f_reg);
        s3_p2_next = P2_W'(HORNER_C1) + P2_W'(q2[P1_W+F_W-1:F_W]);
        s3_pc_next = s2_ctr_reg + (ACC_W'(s2_dcl_reg) <<< DELTA_SHIFT);
    end

    always_comb
    begin
        q3         = (P2_W + F_W)'(s3_p2_reg) * (P2_W + F_W)'(s3_f_reg);
        s4_p3_next = P3_W'(HORNER_C0) + P3_W'(q3[P2_W+F_W-1:F_W]);
    end

    // exp = m << sh
    always_comb
    begin
        shr        = N_W'(-s4_n_reg);
        s5_m_next  = '0;
        s5_sh_next = '0;
        if (s4_n_reg > EXP_CAP_N)
        begin
            s5_m_next  = P3_W'(1);
            s5_sh_next = SH_W'(EXP_CAP_SH);
        end
        else if (s4_n_reg >= 0)
        begin
            s5_m_next  = s4_p3_reg;
            s5_sh_next = SH_W'(s4_n_reg);
        end
        else if (s4_n_reg > -EXP_ZERO_N)
        begin
            s5_m_next = s4_p3_reg >> shr;
        end
    end

    always_comb
    begin
        s6_prod_next = PROD_W'($signed({1'b0, s5_m_reg})) * PROD_W'(s5_len_reg);
        s7_half_next = ACC_W'(s6_prod_reg) <<< s6_sh_reg;
    end

    always_comb
    begin
        lo_sum     = s7_pc_reg - s7_half_reg;
        hi_sum     = s7_pc_reg + s7_half_reg;
        s8_lo_next = saturate(lo_sum[ACC_W-1:SCALE_SHIFT]);
        s8_hi_next = saturate(hi_sum[ACC_W-1:SCALE_SHIFT]);
    end

    always_comb
    begin
        bound      = (BOUND_W'($signed({1'b0, size})) - BOUND_W'(1)) <<< COORD_FRAC_BITS;
        s9_lo_next = clip(s8_lo_reg.value, clip_enable, bound);
        s9_hi_next = clip(s8_hi_reg.value, clip_enable, bound);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            s1_t_reg   <= s1_t_next;
            s1_len_reg <= s1_len_next;
            s1_a1_reg  <= a1;
            s1_dc_reg  <= d_ctr;
        end
        if (ctrl.en[1])
        begin
            s2_p1_reg  <= s2_p1_next;
            s2_f_reg   <= f1;
            s2_n_reg   <= s1_t_reg[T_W-1 -: N_W];
            s2_len_reg <= s1_len_reg;
            s2_ctr_reg <= s2_ctr_next;
            s2_dcl_reg <= s2_dcl_next;
        end
        if (ctrl.en[2])
        begin
            s3_p2_reg  <= s3_p2_next;
            s3_f_reg   <= s2_f_reg;
            s3_n_reg   <= s2_n_reg;
            s3_len_reg <= s2_len_reg;
            s3_pc_reg  <= s3_pc_next;
        end
        if (ctrl.en[3])
        begin
            s4_p3_reg  <= s4_p3_next;
            s4_n_reg   <= s3_n_reg;
            s4_len_reg <= s3_len_reg;
            s4_pc_reg  <= s3_pc_reg;
        end
        if (ctrl.en[4])
        begin
            s5_m_reg   <= s5_m_next;
            s5_sh_reg  <= s5_sh_next;
            s5_len_reg <= s4_len_reg;
            s5_pc_reg  <= s4_pc_reg;
        end
        if (ctrl.en[5])
        begin
            s6_prod_reg <= s6_prod_next;
            s6_sh_reg   <= s5_sh_reg;
            s6_pc_reg   <= s5_pc_reg;
        end
        if (ctrl.en[6])
        begin
            s7_half_reg <= s7_half_next;
            s7_pc_reg   <= s6_pc_reg;
        end
        if (ctrl.en[7])
        begin
            s8_lo_reg <= s8_lo_next;
            s8_hi_reg <= s8_hi_next;
        end
        if (ctrl.en[8])
        begin
            s9_lo_reg  <= s9_lo_next;
            s9_hi_reg  <= s9_hi_next;
            s9_sat_reg <= s8_lo_reg.flag | s8_hi_reg.flag;
        end
    end

    assign lo  = s9_lo_reg;
    assign hi  = s9_hi_reg;
    assign sat = s9_sat_reg;

endmodule
